@@ sv/cfglc_pkg.sv @@
// ----------------------------------------------------------------------------
// cfglc_pkg
// Shared types and constants of the config line classifier: record kinds,
// first-character classes, character codes and the record bundle.
// ----------------------------------------------------------------------------
package cfglc_pkg;

  // Text length above which offsets are flagged unreliable.
  localparam int unsigned MaxTextBytes = 65536;
  localparam int unsigned PosLimit     = (MaxTextBytes < 65536) ? MaxTextBytes : 65536;

  // Byte position counter saturates at this value.
  localparam int unsigned PosWidth = 31;
  localparam logic [PosWidth-1:0] PosCap = {PosWidth{1'b1}};

  // Most records one input item can cause.
  localparam int unsigned MaxResults = 3;

  // Character codes.
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChCaret   = 8'h5E;
  localparam logic [7:0] ChEqual   = 8'h3D;
  localparam logic [7:0] ChLBrack  = 8'h5B;
  localparam logic [7:0] ChRBrack  = 8'h5D;
  localparam logic [7:0] ChLBrace  = 8'h7B;
  localparam logic [7:0] ChRBrace  = 8'h7D;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;

  // Scope depth limits.
  localparam logic signed [7:0] DepthMax = 8'sd127;
  localparam logic signed [7:0] DepthMin = -8'sd128;

  typedef enum logic [3:0] {
    KIND_COMMENT   = 4'd0,
    KIND_SECTION   = 4'd1,
    KIND_OPEN      = 4'd2,
    KIND_CLOSE     = 4'd3,
    KIND_KEY_VALUE = 4'd4,
    KIND_MULTILINE = 4'd5,
    KIND_PLAIN     = 4'd6,
    KIND_VALUE_END = 4'd7,
    KIND_END       = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    FCC_OTHER   = 3'd0,
    FCC_HASH    = 3'd1,
    FCC_BRACKET = 3'd2,
    FCC_OPEN    = 3'd3,
    FCC_CLOSE   = 3'd4
  } fcc_t;

  // One result record.
  typedef struct packed {
    kind_t             kind;
    logic [15:0]       line_start;
    logic [15:0]       line_end;
    logic [15:0]       key_start;
    logic [15:0]       key_end;
    logic [15:0]       value_start;
    logic [15:0]       value_end;
    logic signed [7:0] nesting_depth;
    logic              position_overflow;
    logic              last;
  } rec_t;

  // All records caused by one input item, in delivery order from index 0.
  typedef struct packed {
    logic [1:0]                count;
    rec_t [MaxResults-1:0]     recs;
  } bundle_t;

  // Whitespace: space, tab, LF, VT, FF or CR.
  function automatic logic is_blank(input logic [7:0] b);
    return (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
  endfunction

endpackage

@@ sv/cfglc_scan.sv @@
// ----------------------------------------------------------------------------
// cfglc_scan
// Line scanner state and record builder. Updates the scanner state for each
// accepted item and presents, in the same cycle, the records that it causes.
// ----------------------------------------------------------------------------
module cfglc_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        text_byte,
  input  logic              end_mark,
  output cfglc_pkg::bundle_t results
);
  import cfglc_pkg::*;

  // Scanner state.
  logic [PosWidth-1:0] pos;
  logic                in_line;
  logic [15:0]         origin;
  fcc_t                fcc;
  logic                eq_seen;
  logic [15:0]         eq_pos;
  logic                caret_seen;
  logic [15:0]         caret_pos;
  logic                caret_adj;
  logic                multi_key;
  logic                close_seen;
  logic [15:0]         close_pos;
  logic                rest_blank;
  logic [7:0]          prev1;
  logic [7:0]          prev2;
  logic [1:0]          pend;
  logic [1:0]          age;
  logic signed [7:0]   depth;
  logic                ovf;

  logic [PosWidth-1:0] pos_next;
  logic                in_line_next;
  logic [15:0]         origin_next;
  fcc_t                fcc_next;
  logic                eq_seen_next;
  logic [15:0]         eq_pos_next;
  logic                caret_seen_next;
  logic [15:0]         caret_pos_next;
  logic                caret_adj_next;
  logic                multi_key_next;
  logic                close_seen_next;
  logic [15:0]         close_pos_next;
  logic                rest_blank_next;
  logic [7:0]          prev1_next;
  logic [7:0]          prev2_next;
  logic [1:0]          pend_next;
  logic [1:0]          age_next;
  logic signed [7:0]   depth_next;
  logic                ovf_next;

  logic        ovf_eff;
  logic [15:0] p16;
  logic        term;
  logic        blank;
  logic        not_capped;
  fcc_t        byte_class;

  rec_t              line_rec;
  rec_t              ve_rec;
  rec_t              end_rec;
  logic signed [7:0] depth_cls;
  logic              arm_cls;
  logic [1:0]        pend_aged;
  logic [1:0]        age_aged;
  logic              match;

  assign ovf_eff    = ovf | (pos >= PosWidth'(PosLimit));
  assign p16        = pos[15:0];
  assign term       = (text_byte == ChCr) || (text_byte == ChLf);
  assign blank      = is_blank(text_byte);
  assign not_capped = (pos != PosCap);

  // Class of a line's first character.
  always_comb begin
    priority if (text_byte == ChHash)   byte_class = FCC_HASH;
    else if     (text_byte == ChLBrack) byte_class = FCC_BRACKET;
    else if     (text_byte == ChLBrace) byte_class = FCC_OPEN;
    else if     (text_byte == ChRBrace) byte_class = FCC_CLOSE;
    else                                byte_class = FCC_OTHER;
  end

  // Line classification; the line ends at the current offset.
  always_comb begin
    line_rec                   = '0;
    line_rec.line_start        = origin;
    line_rec.line_end          = p16;
    line_rec.position_overflow = ovf_eff;
    depth_cls                  = depth;
    arm_cls                    = 1'b0;
    priority if (fcc == FCC_HASH) begin
      line_rec.kind      = KIND_COMMENT;
      line_rec.key_start = origin + 16'd1;
      line_rec.key_end   = p16;
    end else if (fcc == FCC_BRACKET && close_seen) begin
      line_rec.kind      = KIND_SECTION;
      line_rec.key_start = origin + 16'd1;
      line_rec.key_end   = close_pos;
    end else if (fcc == FCC_OPEN && rest_blank) begin
      line_rec.kind      = KIND_OPEN;
      line_rec.key_start = origin;
      line_rec.key_end   = origin + 16'd1;
      if (depth != DepthMax) depth_cls = depth + 8'sd1;
    end else if (fcc == FCC_CLOSE && rest_blank) begin
      line_rec.kind      = KIND_CLOSE;
      line_rec.key_start = origin;
      line_rec.key_end   = origin + 16'd1;
      if (depth != DepthMin) depth_cls = depth - 8'sd1;
    end else if (eq_seen && multi_key) begin
      line_rec.kind        = KIND_MULTILINE;
      line_rec.key_start   = origin;
      line_rec.key_end     = caret_pos;
      line_rec.value_start = eq_pos + 16'd1;
      arm_cls              = 1'b1;
    end else if (eq_seen) begin
      line_rec.kind        = KIND_KEY_VALUE;
      line_rec.key_start   = origin;
      line_rec.key_end     = eq_pos;
      line_rec.value_start = eq_pos + 16'd1;
      line_rec.value_end   = p16;
    end else begin
      line_rec.kind      = KIND_PLAIN;
      line_rec.key_start = origin;
      line_rec.key_end   = p16;
    end
    line_rec.nesting_depth = depth_cls;
  end

  // Multiline arming ages over three bytes, then the LF '^' terminator
  // sequence may close it.
  always_comb begin
    pend_aged = pend;
    age_aged  = age;
    if (pend[1]) begin
      age_aged = age + 2'd1;
      if (age == 2'd2) pend_aged = 2'b01;
    end
  end

  assign match = term && (prev2 == ChLf) && (prev1 == ChCaret) && pend_aged[0];

  // Value end and end-of-text records.
  always_comb begin
    ve_rec                   = '0;
    ve_rec.kind              = KIND_VALUE_END;
    ve_rec.position_overflow = ovf_eff;
    end_rec                  = '0;
    end_rec.kind             = KIND_END;
    end_rec.line_end         = p16;
    end_rec.position_overflow = ovf_eff;
    end_rec.last             = 1'b1;
    if (end_mark) begin
      ve_rec.value_end     = p16;
      ve_rec.nesting_depth = in_line ? depth_cls : depth;
      end_rec.nesting_depth = in_line ? depth_cls : depth;
    end else begin
      ve_rec.value_end     = p16 - 16'd2;
      ve_rec.nesting_depth = depth;
    end
  end

  // Record bundle in delivery order.
  always_comb begin
    logic [1:0] n;
    rec_t       ln;
    n       = 2'd0;
    ln      = line_rec;
    results = '0;
    if (end_mark) begin
      if (in_line) begin
        results.recs[n] = ln;
        n = n + 2'd1;
      end
      if ((pend != 2'b00) || (in_line && arm_cls)) begin
        results.recs[n] = ve_rec;
        n = n + 2'd1;
      end
      results.recs[n] = end_rec;
      n = n + 2'd1;
    end else begin
      if (match) begin
        results.recs[n] = ve_rec;
        n = n + 2'd1;
      end
      if (in_line && term) begin
        ln.last = 1'b1;
        results.recs[n] = ln;
        n = n + 2'd1;
      end else if (match) begin
        results.recs[0].last = 1'b1;
      end
    end
    results.count = n;
  end

  // Next state.
  always_comb begin
    pos_next        = pos;
    in_line_next    = in_line;
    origin_next     = origin;
    fcc_next        = fcc;
    eq_seen_next    = eq_seen;
    eq_pos_next     = eq_pos;
    caret_seen_next = caret_seen;
    caret_pos_next  = caret_pos;
    caret_adj_next  = 1'b0;
    multi_key_next  = multi_key;
    close_seen_next = close_seen;
    close_pos_next  = close_pos;
    rest_blank_next = rest_blank;
    prev1_next      = text_byte;
    prev2_next      = prev1;
    pend_next       = match ? (pend_aged & 2'b10) : pend_aged;
    age_next        = age_aged;
    depth_next      = depth;
    ovf_next        = ovf_eff;
    if (end_mark) begin
      // End of text returns everything to the reset state.
      pos_next        = '0;
      in_line_next    = 1'b0;
      origin_next     = '0;
      fcc_next        = FCC_OTHER;
      eq_seen_next    = 1'b0;
      eq_pos_next     = '0;
      caret_seen_next = 1'b0;
      caret_pos_next  = '0;
      multi_key_next  = 1'b0;
      close_seen_next = 1'b0;
      close_pos_next  = '0;
      rest_blank_next = 1'b1;
      prev1_next      = '0;
      prev2_next      = '0;
      pend_next       = '0;
      age_next        = '0;
      depth_next      = '0;
      ovf_next        = 1'b0;
    end else begin
      if (!in_line) begin
        if (!blank) begin
          in_line_next    = 1'b1;
          origin_next     = p16;
          fcc_next        = byte_class;
          eq_seen_next    = (text_byte == ChEqual);
          eq_pos_next     = p16;
          caret_seen_next = (text_byte == ChCaret);
          caret_pos_next  = p16;
          caret_adj_next  = (text_byte == ChCaret) && not_capped;
          multi_key_next  = 1'b0;
          close_seen_next = (text_byte == ChRBrack);
          close_pos_next  = p16;
          rest_blank_next = 1'b1;
        end
      end else if (term) begin
        in_line_next = 1'b0;
        depth_next   = depth_cls;
        if (arm_cls) begin
          pend_next = pend_next | 2'b10;
          age_next  = 2'd0;
        end
      end else begin
        if (text_byte == ChEqual && !eq_seen) begin
          eq_seen_next   = 1'b1;
          eq_pos_next    = p16;
          multi_key_next = caret_adj;
        end
        if (text_byte == ChCaret && !caret_seen) begin
          caret_seen_next = 1'b1;
          caret_pos_next  = p16;
          caret_adj_next  = not_capped;
        end
        if (text_byte == ChRBrack && !close_seen) begin
          close_seen_next = 1'b1;
          close_pos_next  = p16;
        end
        if (!blank) rest_blank_next = 1'b0;
      end
      if (not_capped) pos_next = pos + PosWidth'(1);
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      in_line    <= 1'b0;
      origin     <= '0;
      fcc        <= FCC_OTHER;
      eq_seen    <= 1'b0;
      eq_pos     <= '0;
      caret_seen <= 1'b0;
      caret_pos  <= '0;
      caret_adj  <= 1'b0;
      multi_key  <= 1'b0;
      close_seen <= 1'b0;
      close_pos  <= '0;
      rest_blank <= 1'b1;
      prev1      <= '0;
      prev2      <= '0;
      pend       <= '0;
      age        <= '0;
      depth      <= '0;
      ovf        <= 1'b0;
    end else if (accept) begin
      pos        <= pos_next;
      in_line    <= in_line_next;
      origin     <= origin_next;
      fcc        <= fcc_next;
      eq_seen    <= eq_seen_next;
      eq_pos     <= eq_pos_next;
      caret_seen <= caret_seen_next;
      caret_pos  <= caret_pos_next;
      caret_adj  <= caret_adj_next;
      multi_key  <= multi_key_next;
      close_seen <= close_seen_next;
      close_pos  <= close_pos_next;
      rest_blank <= rest_blank_next;
      prev1      <= prev1_next;
      prev2      <= prev2_next;
      pend       <= pend_next;
      age        <= age_next;
      depth      <= depth_next;
      ovf        <= ovf_next;
    end
  end

endmodule

@@ sv/cfglc_out_queue.sv @@
// ----------------------------------------------------------------------------
// cfglc_out_queue
// Result register: holds the records of one item and hands them out one per
// transaction. Takes the next item while its final record is being taken.
// ----------------------------------------------------------------------------
module cfglc_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  cfglc_pkg::bundle_t bundle,
  input  logic               out_ready,
  output logic               out_valid,
  output cfglc_pkg::rec_t    out_rec,
  output logic               in_ready
);
  import cfglc_pkg::*;

  rec_t [MaxResults-1:0] recs;
  logic [1:0]            head;
  logic [1:0]            count;

  assign out_valid = (count != 2'd0);
  assign out_rec   = recs[head];
  assign in_ready  = (count == 2'd0) || ((count == 2'd1) && out_ready);

  // Record payload.
  always_ff @(posedge clk) begin
    if (load && bundle.count != 2'd0) recs <= bundle.recs;
  end

  // Read pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (load && bundle.count != 2'd0) begin
      head  <= '0;
      count <= bundle.count;
    end else if (out_valid && out_ready) begin
      head  <= head + 2'd1;
      count <= count - 2'd1;
    end
  end

endmodule

@@ sv/config_line_classifier.sv @@
// ----------------------------------------------------------------------------
// config_line_classifier
// Stream tokenizer for line-oriented configuration text: one byte per
// transaction in, one classification record per transaction out.
// ----------------------------------------------------------------------------
// The first record of a byte appears in the cycle after its acceptance.
// Throughput: one byte per cycle without back-pressure; an item causing k
// records stalls the input until its final record is being taken.
// Reset (rst, synchronous): scanner returns to the start-of-text state and
// the result register empties.
module config_line_classifier (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] text_byte
  input  logic [0:0]   s_axis_tuser,  // [0] end_mark
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] line_start, [31:16] line_end, [47:32] key_start, [63:48] key_end,
  // [79:64] value_start, [95:80] value_end, [103:96] nesting_depth,
  // [104] position_overflow, [111:105] zero
  output logic [111:0] m_axis_tdata,
  output logic [3:0]   m_axis_tuser,  // [3:0] kind
  output logic         m_axis_tlast
);
  import cfglc_pkg::*;

  logic    accept;
  bundle_t results;
  rec_t    out_rec;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Scanner state and record builder.
  cfglc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (s_axis_tdata),
    .end_mark  (s_axis_tuser[0]),
    .results   (results)
  );

  // Result register.
  cfglc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .bundle    (results),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_rec   (out_rec),
    .in_ready  (s_axis_tready)
  );

  // Output packing.
  assign m_axis_tdata = {7'd0, out_rec.position_overflow, out_rec.nesting_depth,
                         out_rec.value_end, out_rec.value_start, out_rec.key_end,
                         out_rec.key_start, out_rec.line_end, out_rec.line_start};
  assign m_axis_tuser = out_rec.kind;
  assign m_axis_tlast = out_rec.last;

  // The input only stalls while records are waiting.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty result register");

  // End of text always yields at least the end record.
  assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tuser[0]) |=> m_axis_tvalid)
    else $error("end of text produced no record");

  // The end record is the final record of its item.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_END) |-> m_axis_tlast)
    else $error("end record not marked last");

  // A record that is not the item's final one blocks new input.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("new item accepted while records of the previous one remain");

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the config line classifier. Text bytes and end of
// text marks are streamed in. Every accepted transaction runs through a local
// line scanner that predicts the records the block should emit. Each output
// transaction is checked against the oldest predicted record. A short table
// of hand-picked bytes comes first, and random documents follow.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cfglc_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomItems = 355;
  localparam int unsigned QuietItems  = 90;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReported = 10;

  // Blank characters and the letter base that the package does not provide.
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChLowerA = 8'h61;

  // Records that can be read straight off the input bytes.
  localparam rec_t NoRec       = '0;
  localparam rec_t EndAtZero   = '{kind: KIND_END, last: 1'b1, default: '0};
  localparam rec_t CommentAtOne = '{kind: KIND_COMMENT, line_start: 16'd1, line_end: 16'd2,
                                    key_start: 16'd2, key_end: 16'd2, last: 1'b1,
                                    default: '0};

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    bit         typed;
    rec_t       want;
  } stim_row_t;

  // Hand-picked bytes: every record kind, byte extremes, a newly armed
  // multiline key whose own terminator must not close it, a later value end,
  // and a multiline value left open at the end of text.
  stim_row_t directed_rows [26] = '{
    '{8'h00,    1'b1, 1'b1, EndAtZero},
    '{ChSpace,  1'b0, 1'b0, NoRec},
    '{ChHash,   1'b0, 1'b0, NoRec},
    '{ChLf,     1'b0, 1'b1, CommentAtOne},
    '{ChLBrack, 1'b0, 1'b0, NoRec},
    '{ChRBrack, 1'b0, 1'b0, NoRec},
    '{ChLf,     1'b0, 1'b0, NoRec},
    '{ChLBrace, 1'b0, 1'b0, NoRec},
    '{ChLf,     1'b0, 1'b0, NoRec},
    '{ChRBrace, 1'b0, 1'b0, NoRec},
    '{ChCr,     1'b0, 1'b0, NoRec},
    '{8'hFF,    1'b0, 1'b0, NoRec},
    '{ChEqual,  1'b0, 1'b0, NoRec},
    '{8'h00,    1'b0, 1'b0, NoRec},
    '{ChLf,     1'b0, 1'b0, NoRec},
    '{ChCaret,  1'b0, 1'b0, NoRec},
    '{ChEqual,  1'b0, 1'b0, NoRec},
    '{ChLf,     1'b0, 1'b0, NoRec},
    '{ChCaret,  1'b0, 1'b0, NoRec},
    '{ChLf,     1'b0, 1'b0, NoRec},
    '{ChCaret,  1'b0, 1'b0, NoRec},
    '{ChLf,     1'b0, 1'b0, NoRec},
    '{ChCaret,  1'b0, 1'b0, NoRec},
    '{ChEqual,  1'b0, 1'b0, NoRec},
    '{ChLf,     1'b0, 1'b0, NoRec},
    '{8'hFF,    1'b1, 1'b0, NoRec}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         m_axis_tlast;

  bit          idle_on = 1'b1;
  int unsigned sink_stall = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned fail_count = 0;

  // Records predicted for the current transaction, and all still awaited.
  rec_t step_recs[$];
  rec_t awaited_recs[$];
  logic [7:0] doc_bytes[$];

  // Scanner state of the predictor.
  int unsigned scan_pos;
  bit          scan_in_line;
  int unsigned scan_origin;
  fcc_t        scan_fcc;
  bit          eq_hit;
  int unsigned eq_at;
  bit          caret_hit;
  int unsigned caret_at;
  bit          rbrack_hit;
  int unsigned rbrack_at;
  bit          only_blanks;
  logic [7:0]  last_byte;
  logic [7:0]  byte_before;
  logic [1:0]  ml_armed;  // bit 0: able to match, bit 1: newly armed
  int unsigned ml_age;
  int          scope_depth;
  bit          offs_overflow;

  config_line_classifier i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line scanner predictor.
  // ---------------------------------------------------------------------------

  function automatic bit is_space_char(input logic [7:0] ch);
    return (ch == ChSpace) || (ch >= ChTab && ch <= ChCr);
  endfunction

  function automatic void clear_scanner();
    scan_pos      = 0;
    scan_in_line  = 1'b0;
    scan_origin   = 0;
    scan_fcc      = FCC_OTHER;
    eq_hit        = 1'b0;
    eq_at         = 0;
    caret_hit     = 1'b0;
    caret_at      = 0;
    rbrack_hit    = 1'b0;
    rbrack_at     = 0;
    only_blanks   = 1'b1;
    last_byte     = '0;
    byte_before   = '0;
    ml_armed      = 2'b00;
    ml_age        = 0;
    scope_depth   = 0;
    offs_overflow = 1'b0;
  endfunction

  function automatic void add_rec(input kind_t k, input int unsigned ls, input int unsigned le,
                                  input int unsigned ks, input int unsigned ke,
                                  input int unsigned vs, input int unsigned ve);
    rec_t r;
    r.kind              = k;
    r.line_start        = 16'(ls);
    r.line_end          = 16'(le);
    r.key_start         = 16'(ks);
    r.key_end           = 16'(ke);
    r.value_start       = 16'(vs);
    r.value_end         = 16'(ve);
    r.nesting_depth     = scope_depth[7:0];
    r.position_overflow = offs_overflow;
    r.last              = 1'b0;
    step_recs.push_back(r);
  endfunction

  // Only the first '=', '^' and ']' of a line are remembered.
  function automatic void note_marks(input logic [7:0] ch, input int unsigned p);
    if (ch == ChEqual && !eq_hit) begin
      eq_hit = 1'b1;
      eq_at  = p;
    end
    if (ch == ChCaret && !caret_hit) begin
      caret_hit = 1'b1;
      caret_at  = p;
    end
    if (ch == ChRBrack && !rbrack_hit) begin
      rbrack_hit = 1'b1;
      rbrack_at  = p;
    end
  endfunction

  // Classify the open line that ends at offset le.
  function automatic void close_line(input int unsigned le);
    int unsigned ls;
    ls = scan_origin;
    if (scan_fcc == FCC_HASH) begin
      add_rec(KIND_COMMENT, ls, le, ls + 1, le, 0, 0);
    end else if (scan_fcc == FCC_BRACKET && rbrack_hit) begin
      add_rec(KIND_SECTION, ls, le, ls + 1, rbrack_at, 0, 0);
    end else if (scan_fcc == FCC_OPEN && only_blanks) begin
      if (scope_depth < DepthMax) scope_depth++;
      add_rec(KIND_OPEN, ls, le, ls, ls + 1, 0, 0);
    end else if (scan_fcc == FCC_CLOSE && only_blanks) begin
      if (scope_depth > DepthMin) scope_depth--;
      add_rec(KIND_CLOSE, ls, le, ls, ls + 1, 0, 0);
    end else if (eq_hit) begin
      if (caret_hit && caret_at + 1 == eq_at) begin
        ml_armed = ml_armed | 2'b10;
        ml_age   = 0;
        add_rec(KIND_MULTILINE, ls, le, ls, caret_at, eq_at + 1, 0);
      end else begin
        add_rec(KIND_KEY_VALUE, ls, le, ls, eq_at, eq_at + 1, le);
      end
    end else begin
      add_rec(KIND_PLAIN, ls, le, ls, le, 0, 0);
    end
  endfunction

  // Work out the records caused by one accepted transaction.
  function automatic void classify_input(input logic [7:0] ch, input logic eot);
    int unsigned p;
    bit          is_term;
    p = scan_pos;
    step_recs.delete();
    if (p >= PosLimit) offs_overflow = 1'b1;
    if (eot) begin
      // Open line first, then any open multiline value, then the end record.
      if (scan_in_line) close_line(p);
      if (ml_armed != 2'b00) add_rec(KIND_VALUE_END, 0, 0, 0, 0, 0, p);
      add_rec(KIND_END, 0, p, 0, 0, 0, 0);
      clear_scanner();
    end else begin
      is_term = (ch == ChCr) || (ch == ChLf);
      // A new multiline key may match only from its third following byte.
      if (ml_armed[1]) begin
        ml_age++;
        if (ml_age >= 3) ml_armed = 2'b01;
      end
      if (is_term && byte_before == ChLf && last_byte == ChCaret && ml_armed[0]) begin
        add_rec(KIND_VALUE_END, 0, 0, 0, 0, 0, p - 2);
        ml_armed = ml_armed & 2'b10;
      end
      if (!scan_in_line) begin
        if (!is_space_char(ch)) begin
          scan_in_line = 1'b1;
          scan_origin  = p;
          case (ch)
            ChHash:   scan_fcc = FCC_HASH;
            ChLBrack: scan_fcc = FCC_BRACKET;
            ChLBrace: scan_fcc = FCC_OPEN;
            ChRBrace: scan_fcc = FCC_CLOSE;
            default:  scan_fcc = FCC_OTHER;
          endcase
          eq_hit      = 1'b0;
          caret_hit   = 1'b0;
          rbrack_hit  = 1'b0;
          only_blanks = 1'b1;
          note_marks(ch, p);
        end
      end else if (is_term) begin
        close_line(p);
        scan_in_line = 1'b0;
      end else begin
        note_marks(ch, p);
        if (!is_space_char(ch)) only_blanks = 1'b0;
      end
      byte_before = last_byte;
      last_byte   = ch;
      if (scan_pos < PosCap) scan_pos++;
    end
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChVt;
      default: return ChFf;
    endcase
  endfunction

  // Short text biased toward the characters the scanner reacts to.
  function automatic void add_text(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 15))
        0:       doc_bytes.push_back(8'($urandom_range(0, 255)));
        1:       doc_bytes.push_back(ChSpace);
        2:       doc_bytes.push_back(ChCaret);
        3:       doc_bytes.push_back(ChEqual);
        4:       doc_bytes.push_back(ChRBrack);
        5:       doc_bytes.push_back(ChHash);
        6:       doc_bytes.push_back(ChLBrace);
        7:       doc_bytes.push_back(ChRBrace);
        8:       doc_bytes.push_back(ChLBrack);
        9:       doc_bytes.push_back(ChTab);
        default: doc_bytes.push_back(ChLowerA + 8'($urandom_range(0, 25)));
      endcase
    end
  endfunction

  function automatic string rec_text(input rec_t r);
    return $sformatf({"kind %0d ls %0d le %0d ks %0d ke %0d vs %0d ve %0d depth %0d",
                      " ovf %0b last %0b"},
                     r.kind, r.line_start, r.line_end, r.key_start, r.key_end,
                     r.value_start, r.value_end, r.nesting_depth,
                     r.position_overflow, r.last);
  endfunction

  // Offer one transaction, entered and left at a falling edge. A typed row
  // replaces the predicted records with the one written in the table.
  task automatic feed(input logic [7:0] ch, input logic eot, input bit typed,
                      input rec_t want);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= eot;
    do @(posedge clk); while (!s_axis_tready);
    classify_input(ch, eot);
    if (typed) begin
      awaited_recs.push_back(want);
    end else begin
      foreach (step_recs[i]) awaited_recs.push_back(step_recs[i]);
    end
    items_sent++;
    @(negedge clk);
  endtask

  // Stream the composed document followed by its end of text mark.
  task automatic feed_document();
    foreach (doc_bytes[i]) feed(doc_bytes[i], 1'b0, 1'b0, NoRec);
    feed(8'($urandom_range(0, 255)), 1'b1, 1'b0, NoRec);
  endtask

  // Hold the input idle until every predicted record has been received.
  task automatic await_drain();
    s_axis_tvalid <= 1'b0;
    while (awaited_recs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and record checking.
  // ---------------------------------------------------------------------------

  assign m_axis_tready = (sink_stall == 0);

  always @(negedge clk) begin
    if (sink_stall != 0) begin
      sink_stall <= sink_stall - 1;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      sink_stall <= $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin
    rec_t seen;
    rec_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.kind              = kind_t'(m_axis_tuser);
      seen.line_start        = m_axis_tdata[15:0];
      seen.line_end          = m_axis_tdata[31:16];
      seen.key_start         = m_axis_tdata[47:32];
      seen.key_end           = m_axis_tdata[63:48];
      seen.value_start       = m_axis_tdata[79:64];
      seen.value_end         = m_axis_tdata[95:80];
      seen.nesting_depth     = m_axis_tdata[103:96];
      seen.position_overflow = m_axis_tdata[104];
      seen.last              = m_axis_tlast;
      if (awaited_recs.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReported) begin
          $display("cycle %0d: record with none awaited: %s", cycle_count, rec_text(seen));
        end
      end else begin
        want = awaited_recs.pop_front();
        if (seen !== want) begin
          fail_count++;
          if (fail_count <= MaxReported) begin
            $display("cycle %0d: record mismatch\n  expected %s\n  actual   %s",
                     cycle_count, rec_text(want), rec_text(seen));
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned random_base;
    int unsigned line_count;
    clear_scanner();
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Hand-picked bytes.
    foreach (directed_rows[i]) begin
      feed(directed_rows[i].ch, directed_rows[i].eot, directed_rows[i].typed,
           directed_rows[i].want);
    end
    await_drain();

    // Random documents built mostly from well-formed lines with random content.
    random_base = items_sent;
    while (items_sent - random_base < RandomItems) begin
      doc_bytes.delete();
      line_count = $urandom_range(1, 12);
      for (int unsigned l = 0; l < line_count; l++) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) doc_bytes.push_back(pick_blank());
        end
        case ($urandom_range(0, 19))
          0, 1: begin
            doc_bytes.push_back(ChHash);
            add_text($urandom_range(0, 6));
          end
          2, 3: begin
            doc_bytes.push_back(ChLBrack);
            add_text($urandom_range(0, 4));
            if ($urandom_range(0, 3) != 0) doc_bytes.push_back(ChRBrack);
            add_text($urandom_range(0, 3));
          end
          4, 5: begin
            doc_bytes.push_back(($urandom_range(0, 1) == 0) ? ChLBrace : ChRBrace);
            if ($urandom_range(0, 2) == 0) begin
              add_text($urandom_range(1, 2));
            end else begin
              repeat ($urandom_range(0, 2)) doc_bytes.push_back(pick_blank());
            end
          end
          6, 7, 8, 9: begin
            add_text($urandom_range(0, 4));
            doc_bytes.push_back(ChEqual);
            add_text($urandom_range(0, 5));
          end
          10, 11, 12: begin
            add_text($urandom_range(0, 4));
            doc_bytes.push_back(ChCaret);
            doc_bytes.push_back(ChEqual);
            add_text($urandom_range(0, 5));
          end
          13, 14: doc_bytes.push_back(ChCaret);
          15, 16: add_text($urandom_range(1, 6));
          17: ;
          default: begin
            repeat ($urandom_range(0, 6)) doc_bytes.push_back(8'($urandom_range(0, 255)));
          end
        endcase
        case ($urandom_range(0, 9))
          0: doc_bytes.push_back(ChCr);
          1: begin
            doc_bytes.push_back(ChCr);
            doc_bytes.push_back(ChLf);
          end
          default: doc_bytes.push_back(ChLf);
        endcase
      end
      // Some documents stop without a final terminator.
      if ($urandom_range(0, 2) == 0) begin
        while (doc_bytes.size() > 0 &&
               (doc_bytes[doc_bytes.size() - 1] == ChLf ||
                doc_bytes[doc_bytes.size() - 1] == ChCr)) begin
          void'(doc_bytes.pop_back());
        end
      end
      // The closing stretch runs without idling on either side.
      if (items_sent - random_base >= RandomItems - QuietItems) idle_on = 1'b0;
      feed_document();
      if (idle_on && $urandom_range(0, 5) == 0) await_drain();
    end

    await_drain();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && awaited_recs.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ config_line_classifier.f @@
sv/cfglc_pkg.sv
sv/cfglc_scan.sv
sv/cfglc_out_queue.sv
sv/config_line_classifier.sv
tb/sv/testbench.sv
